// ----- hdl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and case codes shared by the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_WIDTH    = 32;
	localparam int FRAC_BITS_DEF = 16;

	// discriminant needs two guard bits over b*b for the 4ac term
	localparam int D_W   = 2 * COEF_WIDTH + 2;
	localparam int SQ_W  = D_W / 2;
	localparam int NUM_W = COEF_WIDTH + 3;
	localparam int DEN_W = COEF_WIDTH + 2;

	localparam int FRONT_LAT = 3;
	localparam int DIV_LAT   = COEF_WIDTH + 2;

	typedef enum logic [2:0] {
		CASE_ALL_X   = 3'd0,
		CASE_NONE    = 3'd1,
		CASE_LINEAR  = 3'd2,
		CASE_NO_REAL = 3'd3,
		CASE_DOUBLE  = 3'd4,
		CASE_TWO     = 3'd5
	} case_code_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] coef_a;
		logic signed [COEF_WIDTH-1:0] coef_b;
		logic signed [COEF_WIDTH-1:0] coef_c;
	} coef_word_t;

	typedef struct packed {
		logic [2:0]                   case_code;
		logic signed [COEF_WIDTH-1:0] root_first;
		logic signed [COEF_WIDTH-1:0] root_second;
		logic                         overflow;
	} root_word_t;

	// travels beside the square root: numerator base and divisor of the roots
	typedef struct packed {
		case_code_t              code;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} sq_meta_t;

endpackage

// ----- hdl/qrs_front.sv -----
// ----------------------------------------------------------------------------
// qrs_front
// Input register, coefficient products, discriminant and case selection.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  coef_word_t coef,
	output logic [D_W-1:0] disc,
	output sq_meta_t   meta
);

	coef_word_t coef_s1;

	logic signed [COEF_WIDTH-1:0] a_s2, b_s2, c_s2;
	logic [2*COEF_WIDTH-1:0]      bb_s2, ac_s2;
	logic [COEF_WIDTH-1:0]        ma, mb, mc;

	logic [D_W-1:0] bbx, ac4, d_full;
	logic           ac_neg, a_zero, b_zero, c_zero;
	case_code_t     code;
	logic [D_W-1:0] disc_s3;
	sq_meta_t       meta_s3;

	always_comb begin
		ma = coef_s1.coef_a[COEF_WIDTH-1] ? -coef_s1.coef_a : coef_s1.coef_a;
		mb = coef_s1.coef_b[COEF_WIDTH-1] ? -coef_s1.coef_b : coef_s1.coef_b;
		mc = coef_s1.coef_c[COEF_WIDTH-1] ? -coef_s1.coef_c : coef_s1.coef_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1 <= coef;
			a_s2    <= coef_s1.coef_a;
			b_s2    <= coef_s1.coef_b;
			c_s2    <= coef_s1.coef_c;
			bb_s2   <= (2*COEF_WIDTH)'(mb) * (2*COEF_WIDTH)'(mb);
			ac_s2   <= (2*COEF_WIDTH)'(ma) * (2*COEF_WIDTH)'(mc);
			disc_s3 <= disc_s3_d();
			meta_s3 <= meta_d();
		end
	end

	always_comb begin
		a_zero = (a_s2 == '0);
		b_zero = (b_s2 == '0);
		c_zero = (c_s2 == '0);
		bbx    = D_W'(bb_s2);
		ac4    = D_W'(ac_s2) << 2;
		ac_neg = (a_s2[COEF_WIDTH-1] != c_s2[COEF_WIDTH-1]) && !c_zero;
		d_full = ac_neg ? bbx + ac4 : bbx - ac4;
		if (a_zero) begin
			if (b_zero)
				code = c_zero ? CASE_ALL_X : CASE_NONE;
			else
				code = CASE_LINEAR;
		end else if (!ac_neg && bbx < ac4) begin
			code = CASE_NO_REAL;
		end else if (!ac_neg && bbx == ac4) begin
			code = CASE_DOUBLE;
		end else begin
			code = CASE_TWO;
		end
	end

	function automatic logic [D_W-1:0] disc_s3_d();
		return (code == CASE_TWO) ? d_full : '0;
	endfunction

	function automatic sq_meta_t meta_d();
		sq_meta_t m;
		m.code = code;
		if (code == CASE_LINEAR) begin
			m.num = -NUM_W'(c_s2);
			m.den = DEN_W'(b_s2);
		end else begin
			m.num = -NUM_W'(b_s2);
			m.den = DEN_W'(a_s2) <<< 1;
		end
		return m;
	endfunction

	assign disc = disc_s3;
	assign meta = meta_s3;

endmodule

// ----- hdl/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage, rounded down.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [D_W-1:0] disc,
	input  sq_meta_t       meta_in,
	output logic [SQ_W-1:0] root,
	output sq_meta_t       meta_out
);

	logic [D_W-1:0] op_s   [SQ_W];
	logic [D_W-1:0] res_s  [SQ_W];
	sq_meta_t       meta_s [SQ_W];

	for (genvar k = 0; k < SQ_W; k++) begin : g_stage
		localparam logic [D_W-1:0] ONE = D_W'(1) << (2 * (SQ_W - 1 - k));
		logic [D_W-1:0] op_p, res_p, trial, op_n, res_n;
		sq_meta_t       meta_p;

		if (k == 0) begin : g_first
			assign op_p   = disc;
			assign res_p  = '0;
			assign meta_p = meta_in;
		end else begin : g_next
			assign op_p   = op_s[k-1];
			assign res_p  = res_s[k-1];
			assign meta_p = meta_s[k-1];
		end

		always_comb begin
			trial = res_p + ONE;
			if (op_p >= trial) begin
				op_n  = op_p - trial;
				res_n = (res_p >> 1) + ONE;
			end else begin
				op_n  = op_p;
				res_n = res_p >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[k]   <= op_n;
				res_s[k]  <= res_n;
				meta_s[k] <= meta_p;
			end
		end
	end

	assign root     = res_s[SQ_W-1][SQ_W-1:0];
	assign meta_out = meta_s[SQ_W-1];

endmodule

// ----- hdl/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined signed fixed-point divide, truncating, saturating to the root range.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [NUM_W-1:0]      num,
	input  logic signed [DEN_W-1:0]      den,
	output logic signed [COEF_WIDTH-1:0] quot,
	output logic                         ovf
);

	localparam int R_W = 2 * COEF_WIDTH + 2 + FRAC_BITS;

	logic [NUM_W-1:0] nm;
	logic [DEN_W-1:0] dm;
	logic [R_W-1:0]   n_full;

	logic [R_W-1:0]   rem_s0;
	logic [DEN_W-1:0] dm_s0;
	logic             neg_s0, big_s0, dz_s0;

	logic [R_W-1:0]        rem_s  [COEF_WIDTH];
	logic [DEN_W-1:0]      dm_s   [COEF_WIDTH];
	logic [COEF_WIDTH-1:0] q_s    [COEF_WIDTH];
	logic                  neg_s  [COEF_WIDTH];
	logic                  big_s  [COEF_WIDTH];
	logic                  dz_s   [COEF_WIDTH];

	logic signed [COEF_WIDTH-1:0] quot_sf;
	logic                         ovf_sf;
	logic [COEF_WIDTH-1:0]        lim, mag;
	logic                         sat, neg_l;

	always_comb begin
		nm     = num[NUM_W-1] ? -num : num;
		dm     = den[DEN_W-1] ? -den : den;
		n_full = R_W'(nm) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s0 <= n_full;
			dm_s0  <= dm;
			neg_s0 <= num[NUM_W-1] != den[DEN_W-1];
			// quotient would not fit the working width
			big_s0 <= n_full >= (R_W'(dm) << COEF_WIDTH);
			dz_s0  <= (dm == '0);
		end
	end

	for (genvar k = 0; k < COEF_WIDTH; k++) begin : g_stage
		localparam int B = COEF_WIDTH - 1 - k;
		logic [R_W-1:0]        rem_p, shf, rem_n;
		logic [DEN_W-1:0]      dm_p;
		logic [COEF_WIDTH-1:0] q_p, q_n;
		logic                  neg_p, big_p, dz_p;

		if (k == 0) begin : g_first
			assign rem_p = rem_s0;
			assign dm_p  = dm_s0;
			assign q_p   = '0;
			assign neg_p = neg_s0;
			assign big_p = big_s0;
			assign dz_p  = dz_s0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign dm_p  = dm_s[k-1];
			assign q_p   = q_s[k-1];
			assign neg_p = neg_s[k-1];
			assign big_p = big_s[k-1];
			assign dz_p  = dz_s[k-1];
		end

		always_comb begin
			shf = R_W'(dm_p) << B;
			q_n = q_p;
			if (rem_p >= shf) begin
				rem_n  = rem_p - shf;
				q_n[B] = 1'b1;
			end else begin
				rem_n = rem_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				dm_s[k]  <= dm_p;
				q_s[k]   <= q_n;
				neg_s[k] <= neg_p;
				big_s[k] <= big_p;
				dz_s[k]  <= dz_p;
			end
		end
	end

	always_comb begin
		neg_l = neg_s[COEF_WIDTH-1];
		lim   = (COEF_WIDTH'(1) << (COEF_WIDTH - 1)) - (neg_l ? '0 : COEF_WIDTH'(1));
		sat   = big_s[COEF_WIDTH-1] || (q_s[COEF_WIDTH-1] > lim);
		mag   = sat ? lim : q_s[COEF_WIDTH-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[COEF_WIDTH-1]) begin
				quot_sf <= '0;
				ovf_sf  <= 1'b0;
			end else begin
				quot_sf <= neg_l ? -mag : mag;
				ovf_sf  <= sat;
			end
		end
	end

	assign quot = quot_sf;
	assign ovf  = ovf_sf;

endmodule

// ----- hdl/quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Fixed-point roots of a*x^2 + b*x + c = 0, one coefficient set per cycle while coef_stall is low.
// ----------------------------------------------------------------------------
// Takes one coefficient word per clock while coef_stall is low and returns one
// root word per word, in order. A word passes the front registers for the
// products and discriminant, the square root stages, a register that forms the
// numerators and, in the two dividers, an entry register, the quotient bit
// stages and a saturation register, then the output register. A one-word skid
// behind the output register lets one more word drain while root_stall is
// high; coef_stall rises when the skid is full and the whole pipeline holds.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       coef_valid,
	output logic       coef_stall,
	input  coef_word_t coef,
	output logic       root_valid,
	input  logic       root_stall,
	output root_word_t root
);

	localparam int TOT_LAT = FRONT_LAT + SQ_W + 1 + DIV_LAT;

	logic adv;
	logic [TOT_LAT-1:0] vld_q;

	logic [D_W-1:0]  disc;
	sq_meta_t        meta_f, meta_r;
	logic [SQ_W-1:0] sroot;

	logic signed [NUM_W-1:0] num1_s, num2_s;
	logic signed [DEN_W-1:0] den_s;
	case_code_t              code_s;
	case_code_t              code_dl [DIV_LAT];

	logic signed [COEF_WIDTH-1:0] r1, r2;
	logic                         ovf1, ovf2;
	root_word_t                   fin;

	root_word_t out_q, skid_q;
	logic       out_valid_q, skid_full_q;

	assign adv        = !skid_full_q;
	assign coef_stall = skid_full_q;

	qrs_front u_front (
		.clk  (clk),
		.en   (adv),
		.coef (coef),
		.disc (disc),
		.meta (meta_f)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.disc     (disc),
		.meta_in  (meta_f),
		.root     (sroot),
		.meta_out (meta_r)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_s <= meta_r.num + NUM_W'(sroot);
			num2_s <= meta_r.num - NUM_W'(sroot);
			den_s  <= meta_r.den;
			code_s <= meta_r.code;
		end
	end

	qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_plus (
		.clk  (clk),
		.en   (adv),
		.num  (num1_s),
		.den  (den_s),
		.quot (r1),
		.ovf  (ovf1)
	);

	qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_minus (
		.clk  (clk),
		.en   (adv),
		.num  (num2_s),
		.den  (den_s),
		.quot (r2),
		.ovf  (ovf2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			code_dl[0] <= code_s;
			for (int i = 1; i < DIV_LAT; i++)
				code_dl[i] <= code_dl[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOT_LAT-2:0], coef_valid};
		end
	end

	// drop the roots a case does not produce
	always_comb begin
		fin.case_code = code_dl[DIV_LAT-1];
		case (code_dl[DIV_LAT-1])
			CASE_LINEAR: begin
				fin.root_first  = r1;
				fin.root_second = '0;
				fin.overflow    = ovf1;
			end
			CASE_DOUBLE: begin
				fin.root_first  = r1;
				fin.root_second = r1;
				fin.overflow    = ovf1;
			end
			CASE_TWO: begin
				fin.root_first  = r1;
				fin.root_second = r2;
				fin.overflow    = ovf1 | ovf2;
			end
			default: begin
				fin.root_first  = '0;
				fin.root_second = '0;
				fin.overflow    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || !root_stall) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= vld_q[TOT_LAT-1];
			end
		end else if (adv && vld_q[TOT_LAT-1]) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !root_stall) begin
			out_q <= skid_full_q ? skid_q : fin;
		end else if (adv && vld_q[TOT_LAT-1]) begin
			skid_q <= fin;
		end
	end

	assign root_valid = out_valid_q;
	assign root       = out_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid holds a word while the output register is empty");

	a_absent_roots_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && (root.case_code == CASE_ALL_X || root.case_code == CASE_NONE ||
		root.case_code == CASE_NO_REAL)
		|-> (root.root_first == '0 && root.root_second == '0 && !root.overflow))
		else $error("roots or overflow set for a case without roots");

	a_double_root_equal: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.case_code == CASE_DOUBLE |-> root.root_first == root.root_second)
		else $error("double root fields differ");

	a_linear_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.case_code == CASE_LINEAR |-> root.root_second == '0)
		else $error("linear case drives a second root");
`endif

endmodule
